>>> src/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants for the next prime trial division block.
// ----------------------------------------------------------------------------
package npt_pkg;

  localparam int unsigned OUT_BITS      = 32;
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_FOUND,
    ST_OVF
  } npt_state_t;

  typedef struct packed {
    logic load;
    logic inc_cand;
    logic div_start;
    logic div_step;
    logic next_div;
    logic capture;
    logic capture_ovf;
  } npt_cmd_t;

  typedef struct packed {
    logic cand_at_limit;
    logic cand_lt_first;
    logic sq_gt_cand;
    logic div_last;
    logic rem_zero;
  } npt_status_t;

endpackage

>>> src/npt_datapath.sv
// ----------------------------------------------------------------------------
// npt_datapath
// Candidate, divisor and square registers, bit serial remainder unit and
// result register.
// ----------------------------------------------------------------------------
module npt_datapath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk,
  input  npt_pkg::npt_cmd_t                cmd,
  input  logic [npt_pkg::OUT_BITS-1:0]     start_value,
  output npt_pkg::npt_status_t             status,
  output logic [npt_pkg::OUT_BITS-1:0]     prime_found,
  output logic                             overflow
);
  import npt_pkg::*;

  localparam int unsigned W   = VALUE_BITS;
  localparam int unsigned SQW = VALUE_BITS + 1;
  localparam int unsigned CW  = $clog2(VALUE_BITS + 1);

  logic [W-1:0]        cand_r;
  logic [W-1:0]        div_r;
  logic [SQW-1:0]      sq_r;
  logic [W-1:0]        dvd_r;
  logic [W-1:0]        rem_r;
  logic [CW-1:0]       cnt_r;
  logic [OUT_BITS-1:0] prime_r;
  logic                ovf_r;

  logic [63:0]         start_ext;
  logic [63:0]         cand_ext;
  logic [W-1:0]        start_w;
  logic [W:0]          rem_sh;
  logic [W:0]          rem_sub;
  logic [W-1:0]        rem_nxt;
  logic [SQW-1:0]      sq_nxt;

  assign start_ext = 64'(start_value);
  assign start_w   = start_ext[W-1:0];
  assign cand_ext  = 64'(cand_r);

  // one restoring division step
  assign rem_sh  = {rem_r, dvd_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign rem_nxt = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];

  // (d+1)^2 = d^2 + 2d + 1
  assign sq_nxt = sq_r + {div_r, 1'b1};

  always_comb begin
    status.cand_at_limit = &cand_r;
    status.cand_lt_first = cand_r < W'(FIRST_DIVISOR);
    status.sq_gt_cand    = sq_r > {1'b0, cand_r};
    status.div_last      = cnt_r == CW'(1);
    status.rem_zero      = rem_r == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r <= start_w;
    end
    if (cmd.inc_cand) begin
      cand_r <= cand_r + W'(1);
      div_r  <= W'(FIRST_DIVISOR);
      sq_r   <= SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
    end
    if (cmd.div_start) begin
      dvd_r <= cand_r;
      rem_r <= '0;
      cnt_r <= CW'(W);
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.next_div) begin
      div_r <= div_r + W'(1);
      sq_r  <= sq_nxt;
    end
    if (cmd.capture) begin
      prime_r <= cand_ext[OUT_BITS-1:0];
      ovf_r   <= 1'b0;
    end
    if (cmd.capture_ovf) begin
      prime_r <= '0;
      ovf_r   <= 1'b1;
    end
  end

  assign prime_found = prime_r;
  assign overflow    = ovf_r;

endmodule

>>> src/npt_ctrl.sv
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer for the candidate search and the per divisor remainder test,
// plus the output word valid flag.
// ----------------------------------------------------------------------------
module npt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  npt_pkg::npt_status_t status,
  output npt_pkg::npt_cmd_t    cmd
);
  import npt_pkg::*;

  npt_state_t state_r;
  npt_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        state_nxt = status.cand_at_limit ? ST_OVF : ST_CHECK;
      end
      ST_CHECK: begin
        if (status.cand_lt_first)   state_nxt = ST_NEXT;
        else if (status.sq_gt_cand) state_nxt = ST_FOUND;
        else                        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = status.rem_zero ? ST_NEXT : ST_CHECK;
      end
      ST_FOUND, ST_OVF: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load        = in_valid;
      ST_NEXT:  cmd.inc_cand    = !status.cand_at_limit;
      ST_CHECK: cmd.div_start   = !status.cand_lt_first && !status.sq_gt_cand;
      ST_DIV:   cmd.div_step    = 1'b1;
      ST_EVAL:  cmd.next_div    = !status.rem_zero;
      ST_FOUND: cmd.capture     = slot_free;
      ST_OVF:   cmd.capture_ovf = slot_free;
      default:  cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.capture || cmd.capture_ovf || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> src/next_prime_trial_division.sv
// ----------------------------------------------------------------------------
// next_prime_trial_division
// Returns the smallest prime above the start value by trial division.
//
//   channel | ports                              | direction
//   in      | in_valid, in_ready, in_start_value | word in
//   out     | out_valid, out_ready,              | word out
//           | out_prime_found, out_overflow      |
//
// each divisor tried runs a check, one remainder bit per cycle and an evaluate
// step; a composite candidate adds a next candidate step to its divisors, the
// prime one that and a final check; accepting the word and loading the result add a step each
// one word in flight; the next word is taken while the result waits in the
// output register, but the search only finishes once that register is free
// synchronous active low reset clears the sequencer and the output valid flag
// ----------------------------------------------------------------------------
module next_prime_trial_division #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [npt_pkg::OUT_BITS-1:0] in_start_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npt_pkg::OUT_BITS-1:0] out_prime_found,
  output logic                         out_overflow
);
  import npt_pkg::*;

  npt_cmd_t    cmd;
  npt_status_t status;

  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  npt_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .start_value (in_start_value),
    .status      (status),
    .prime_found (out_prime_found),
    .overflow    (out_overflow)
  );

  // a word taken starts a search that holds off the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while search in progress");

  // overflow words carry zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_prime_found == '0)
    else $error("overflow word with nonzero prime");

  // a found prime is two or odd
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |->
      (out_prime_found[0] || out_prime_found == OUT_BITS'(FIRST_DIVISOR)))
    else $error("even result other than two");

  // result register only loads when its word is gone or leaving
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture || cmd.capture_ovf) |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

>>> dv/next_prime_trial_division_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_trial_division_tb
// Drives start values into the next prime block and checks each returned
// word against a software trial division search. A directed set of corner
// values is sent first: zero, small values, prime gaps and the top of the
// 32-bit range where no prime is left. Random words follow, mostly of small
// magnitude so that the run stays short. There are three traffic phases:
// sender idles lightly while the receiver stalls heavily, then the opposite,
// then full rate. The sender drains the block between phases.
// ----------------------------------------------------------------------------
module next_prime_trial_division_tb;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned W          = npt_pkg::OUT_BITS;

  typedef struct packed {
    logic [W-1:0] prime;
    logic         ovf;
  } prime_result_t;

  class prime_scoreboard;
    prime_result_t pending_primes[$];
    int unsigned   errors;

    function new();
      errors = 0;
    endfunction

    function prime_result_t next_prime_above(logic [W-1:0] start);
      longint unsigned limit;
      longint unsigned cand;
      longint unsigned d;
      bit              is_prime;
      prime_result_t   r;
      limit   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS);
      cand    = longint'(start) & limit;
      r.prime = '0;
      r.ovf   = 1'b1;
      while (cand < limit) begin
        cand++;
        is_prime = (cand >= npt_pkg::FIRST_DIVISOR);
        for (d = npt_pkg::FIRST_DIVISOR; is_prime && d <= cand / d; d++) begin
          if (cand % d == 0) is_prime = 1'b0;
        end
        if (is_prime) begin
          r.prime = cand[W-1:0];
          r.ovf   = 1'b0;
          break;
        end
      end
      return r;
    endfunction

    function void note_word(logic [W-1:0] start);
      pending_primes.push_back(next_prime_above(start));
    endfunction

    function void check_word(logic [W-1:0] prime, logic ovf);
      prime_result_t want;
      if (pending_primes.size() == 0) begin
        $error("unexpected result word: prime_found %0d overflow %0d", prime, ovf);
        errors++;
        return;
      end
      want = pending_primes.pop_front();
      if (prime !== want.prime) begin
        $error("prime_found: expected %0d, actual %0d", want.prime, prime);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $error("overflow: expected %0d, actual %0d", want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] in_start_value;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_prime_found;
  logic         out_overflow;

  int unsigned     send_gap;
  int unsigned     recv_gap;
  prime_scoreboard sb = new();

  next_prime_trial_division #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_value (in_start_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_found(out_prime_found),
    .out_overflow   (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_gap);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_prime_found, out_overflow);
  end

  task automatic send_word(input logic [W-1:0] start);
    while ($urandom_range(0, 99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_value <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(start);
  endtask

  // mostly small magnitudes, a few wider ones, rarely the top of the range
  function automatic logic [W-1:0] random_start();
    int unsigned  pick;
    int unsigned  width;
    logic [W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 32'hFFFF_FFFF - $urandom_range(0, 2);
    width = (pick < 11) ? $urandom_range(13, 18) : $urandom_range(1, 12);
    v     = $urandom;
    return v & ((32'd1 << width) - 32'd1);
  endfunction

  task automatic wait_drained();
    while (sb.pending_primes.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [W-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                 32'd13, 32'd23, 32'd89, 32'd113, 32'd1000, 32'd4095, 32'd65535,
                 32'd131070, 32'hFFFF_FFFB, 32'hFFFF_FFFD, 32'hFFFF_FFFE,
                 32'hFFFF_FFFF};
    send_gap       = 0;
    recv_gap       = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_start_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap = 7;
          recv_gap = 48;
        end
        1: begin
          send_gap = 48;
          recv_gap = 7;
        end
        default: begin
          send_gap = 0;
          recv_gap = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed[i]) send_word(directed[i]);
      end
      repeat (26) send_word(random_start());
      // hold off until every word in flight has come back
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending_primes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/npt_pkg.sv
src/npt_datapath.sv
src/npt_ctrl.sv
src/next_prime_trial_division.sv
dv/next_prime_trial_division_tb.sv
